// ===== hw/rtl/tilt_pkg.sv =====
// Shared constants, widths and helper functions for the accelerometer tilt block.
// Holds the arctangent table used by the CORDIC stages and the final angle fold.
// No dependencies.
package tilt_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;
    localparam int IN_W             = 16;
    localparam int ROLL_W           = 15;
    localparam int PITCH_W          = 14;
    localparam int DIFF_W           = IN_W + 1;
    localparam int PRESCALE         = 14;
    localparam int SQ_N             = 30;   // root bits of isqrt(s * 2^28)
    localparam int SUM_W            = 32;
    localparam int REM_W            = 32;
    localparam int CW               = 34;   // CORDIC x/y width
    localparam int ZW               = 26;   // angle accumulator, 1/65536 degree
    localparam int ANG_W            = 13;   // first-quadrant angle, 1/64 degree
    localparam int HALF_W           = 14;   // half-circle angle, 1/64 degree

    localparam logic signed [ZW-1:0] DEG90_Z   = 26'sd5898240;
    localparam logic [ANG_W-1:0]     ANG90     = 13'd5760;
    localparam logic [HALF_W-1:0]    ANG180    = 14'd11520;

    // configuration register indexes
    localparam logic CFG_OFFSET_Y = 1'b0;
    localparam logic CFG_OFFSET_Z = 1'b1;

    // per-angle control that travels beside the CORDIC data
    typedef struct packed {
        logic             frc;   // take fval instead of the CORDIC result
        logic [ANG_W-1:0] fval;
        logic             xneg;  // cosine operand negative
        logic             yneg;  // sine operand negative
    } t_ang_flags;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    function automatic logic [ZW-1:0] atan_entry(input int idx);
        logic [ZW-1:0] v;
        case (idx)
            0:  v = 26'd2949120;
            1:  v = 26'd1740967;
            2:  v = 26'd919879;
            3:  v = 26'd466945;
            4:  v = 26'd234379;
            5:  v = 26'd117304;
            6:  v = 26'd58666;
            7:  v = 26'd29335;
            8:  v = 26'd14668;
            9:  v = 26'd7334;
            10: v = 26'd3667;
            11: v = 26'd1833;
            12: v = 26'd917;
            13: v = 26'd458;
            14: v = 26'd229;
            15: v = 26'd115;
            16: v = 26'd57;
            17: v = 26'd29;
            18: v = 26'd14;
            19: v = 26'd7;
            20: v = 26'd4;
            21: v = 26'd2;
            22: v = 26'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // fold a first-quadrant angle into the full circle
    function automatic logic [ROLL_W-1:0] fold_angle(input logic [ANG_W-1:0] a,
                                                     input logic xneg,
                                                     input logic yneg);
        logic [HALF_W-1:0] h;
        logic [ROLL_W-1:0] f;
        h = xneg ? (ANG180 - HALF_W'(a)) : HALF_W'(a);
        f = yneg ? (ROLL_W'(0) - ROLL_W'(h)) : ROLL_W'(h);
        return f;
    endfunction

endpackage

// ===== hw/rtl/accel_tilt_roll_pitch.sv =====
// Roll and pitch from a three-axis accelerometer sample: pipelined square root
// followed by two parallel pipelined vectoring CORDICs. Depends on tilt_pkg.
//
// Channel | Direction | Signals                         | Payload (low bit up)
// --------+-----------+---------------------------------+----------------------------------
// sample  | in        | i_s_tvalid/o_s_tready/i_s_tdata | acc_x[15:0] acc_y acc_z
// angles  | out       | o_m_tvalid/i_m_tready/o_m_tdata | roll[14:0] pitch[13:0] 3'b0
// config  | in        | i_cfg_wr_en/i_cfg_idx/i_cfg_wdata | offset_y (0), offset_z (1)
//
// One request is taken every cycle while the pipeline is not stalled; the depth
// is set by the 30 one-bit-per-stage square root stages plus one stage per CORDIC
// iteration. Reset is synchronous, active low, clears the stage valids and the
// offsets. When the output holds and is not taken, the whole pipeline stalls in
// place.
module accel_tilt_roll_pitch
    import tilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,    // acc_x[15:0], acc_y[31:16], acc_z[47:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // roll_angle[14:0], pitch_angle[28:15], zero
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int V_ENT = 2 + SQ_N;
    localparam int LAT   = V_ENT + 2 + CORDIC_STEPS;

    logic en;
    logic [LAT-1:0] r_vld;
    logic signed [IN_W-1:0] r_off_y, r_off_z;

    // stage A
    logic signed [DIFF_W-1:0] r_a_dy, r_a_dz, r_a_nx;
    logic [30:0] r_a_py, r_a_pz;

    // square root chain, index 0 written by the sum stage
    logic [SUM_W-1:0]         r_s   [0:SQ_N];
    logic [REM_W-1:0]         r_rem [0:SQ_N];
    logic [SQ_N-1:0]          r_q   [0:SQ_N];
    logic signed [DIFF_W-1:0] r_dy  [0:SQ_N];
    logic signed [DIFF_W-1:0] r_dz  [0:SQ_N];
    logic signed [DIFF_W-1:0] r_nx  [0:SQ_N];

    // CORDIC chains, index 0 written by the entry stage
    logic signed [CW-1:0] r_rx [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_ry [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_rz [0:CORDIC_STEPS];
    t_ang_flags           r_rf [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_px [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_py [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_pz [0:CORDIC_STEPS];
    t_ang_flags           r_pf [0:CORDIC_STEPS];

    logic [ROLL_W-1:0]  r_roll;
    logic [PITCH_W-1:0] r_pitch;

    // advance the whole pipe unless the result is held
    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = {3'b000, r_pitch, r_roll};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_OFFSET_Y: r_off_y <= i_cfg_wdata;
                CFG_OFFSET_Z: r_off_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // shift valids with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // stage A: offset differences, negated x, squares
    logic signed [IN_W-1:0] n_ax, n_ay, n_az;
    assign n_ax = i_s_tdata[15:0];
    assign n_ay = i_s_tdata[31:16];
    assign n_az = i_s_tdata[47:32];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dy <= DIFF_W'(n_ay) - DIFF_W'(r_off_y);
            r_a_dz <= DIFF_W'(n_az) - DIFF_W'(r_off_z);
            r_a_nx <= DIFF_W'(0) - DIFF_W'(n_ax);
            r_a_py <= 31'(n_ay * n_ay);
            r_a_pz <= 31'(n_az * n_az);
        end
    end

    // sum stage: y^2 + z^2, seed the root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s[0]   <= SUM_W'(r_a_py) + SUM_W'(r_a_pz);
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_dy[0]  <= r_a_dy;
            r_dz[0]  <= r_a_dz;
            r_nx[0]  <= r_a_nx;
        end
    end

    // square root: one root bit per stage, operand is s * 2^28
    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        localparam int P = SQ_N - 1 - k;
        logic [1:0]       n_pair;
        logic [REM_W+1:0] n_rw, n_trial;
        logic             n_ge;
        if (P >= 2 * PRESCALE / 2) begin : g_hi
            assign n_pair = r_s[k][2*(P-PRESCALE) +: 2];
        end else begin : g_lo
            assign n_pair = 2'b00;
        end
        assign n_rw    = {r_rem[k], n_pair};
        assign n_trial = (REM_W+2)'({r_q[k], 2'b01});
        assign n_ge    = n_rw >= n_trial;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k+1] <= REM_W'(n_ge ? (n_rw - n_trial) : n_rw);
                r_q[k+1]   <= {r_q[k][SQ_N-2:0], n_ge};
                r_s[k+1]   <= r_s[k];
                r_dy[k+1]  <= r_dy[k];
                r_dz[k+1]  <= r_dz[k];
                r_nx[k+1]  <= r_nx[k];
            end
        end
    end

    // entry stage: magnitudes, signs and special cases
    logic [DIFF_W-1:0] n_ady, n_adz, n_anx;
    t_ang_flags        n_rf, n_pf;
    logic [SQ_N-1:0]   n_mag;

    always_comb begin
        n_ady = r_dy[SQ_N][DIFF_W-1] ? DIFF_W'(0) - r_dy[SQ_N] : r_dy[SQ_N];
        n_adz = r_dz[SQ_N][DIFF_W-1] ? DIFF_W'(0) - r_dz[SQ_N] : r_dz[SQ_N];
        n_anx = r_nx[SQ_N][DIFF_W-1] ? DIFF_W'(0) - r_nx[SQ_N] : r_nx[SQ_N];
        n_mag = r_q[SQ_N];
        n_rf.frc  = (n_ady == '0) || (n_adz == '0);
        n_rf.fval = (n_ady == '0) ? '0 : ANG90;
        n_rf.xneg = r_dz[SQ_N][DIFF_W-1];
        n_rf.yneg = r_dy[SQ_N][DIFF_W-1];
        n_pf.frc  = (n_anx == '0) || (n_mag == '0);
        n_pf.fval = (n_anx == '0) ? '0 : ANG90;
        n_pf.xneg = 1'b0;
        n_pf.yneg = r_nx[SQ_N][DIFF_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0] <= CW'({n_adz, {PRESCALE{1'b0}}});
            r_ry[0] <= CW'({n_ady, {PRESCALE{1'b0}}});
            r_rz[0] <= '0;
            r_rf[0] <= n_rf;
            r_px[0] <= CW'(n_mag);
            r_py[0] <= CW'({n_anx, {PRESCALE{1'b0}}});
            r_pz[0] <= '0;
            r_pf[0] <= n_pf;
        end
    end

    // CORDIC vectoring iterations, roll and pitch side by side
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
        logic signed [CW-1:0] n_rx, n_ry, n_px, n_py;
        logic signed [ZW-1:0] n_rz, n_pz, n_t;
        assign n_t = $signed(atan_entry(i));
        always_comb begin
            if (!r_ry[i][CW-1]) begin
                n_rx = r_rx[i] + (r_ry[i] >>> i);
                n_ry = r_ry[i] - (r_rx[i] >>> i);
                n_rz = r_rz[i] + n_t;
            end else begin
                n_rx = r_rx[i] - (r_ry[i] >>> i);
                n_ry = r_ry[i] + (r_rx[i] >>> i);
                n_rz = r_rz[i] - n_t;
            end
            if (!r_py[i][CW-1]) begin
                n_px = r_px[i] + (r_py[i] >>> i);
                n_py = r_py[i] - (r_px[i] >>> i);
                n_pz = r_pz[i] + n_t;
            end else begin
                n_px = r_px[i] - (r_py[i] >>> i);
                n_py = r_py[i] + (r_px[i] >>> i);
                n_pz = r_pz[i] - n_t;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rx[i+1] <= n_rx;
                r_ry[i+1] <= n_ry;
                r_rz[i+1] <= n_rz;
                r_rf[i+1] <= r_rf[i];
                r_px[i+1] <= n_px;
                r_py[i+1] <= n_py;
                r_pz[i+1] <= n_pz;
                r_pf[i+1] <= r_pf[i];
            end
        end
    end

    // output stage: clamp, round to 1/64 degree, fold
    logic signed [ZW-1:0] n_rzc, n_pzc;
    logic [22:0]          n_rsum, n_psum;
    logic [ANG_W-1:0]     n_ra, n_pa;
    logic [ROLL_W-1:0]    n_roll, n_pitch;

    always_comb begin
        n_rzc = r_rz[CORDIC_STEPS];
        if (n_rzc < 0) begin
            n_rzc = '0;
        end else if (n_rzc > DEG90_Z) begin
            n_rzc = DEG90_Z;
        end
        n_pzc = r_pz[CORDIC_STEPS];
        if (n_pzc < 0) begin
            n_pzc = '0;
        end else if (n_pzc > DEG90_Z) begin
            n_pzc = DEG90_Z;
        end
        n_rsum  = n_rzc[22:0] + 23'd512;
        n_psum  = n_pzc[22:0] + 23'd512;
        n_ra    = r_rf[CORDIC_STEPS].frc ? r_rf[CORDIC_STEPS].fval : n_rsum[22:10];
        n_pa    = r_pf[CORDIC_STEPS].frc ? r_pf[CORDIC_STEPS].fval : n_psum[22:10];
        n_roll  = fold_angle(n_ra, r_rf[CORDIC_STEPS].xneg, r_rf[CORDIC_STEPS].yneg);
        n_pitch = fold_angle(n_pa, r_pf[CORDIC_STEPS].xneg, r_pf[CORDIC_STEPS].yneg);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= n_roll;
            r_pitch <= n_pitch[PITCH_W-1:0];
        end
    end

endmodule
